// ===== hw/rtl/dwpd_pkg.sv =====
// Shared types, register codes and constants of the dual-wheel PID drive.
`timescale 1ns / 1ps

package dwpd_pkg;

  // Field and register widths
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned GOAL_W     = 16;
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned DRV_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Internal datapath widths
  localparam int unsigned TRAVEL_W = CNT_W + 1;          // sum or difference of two counts
  localparam int unsigned ERR_W    = CNT_W + 2;          // distance / heading error
  localparam int unsigned DIFF_W   = ERR_W + 1;          // error minus previous error
  localparam int unsigned SUM_W    = 40;                 // saturating error sum
  localparam int unsigned SUM_LO_W = SUM_W / 2;          // low half of the split sum
  localparam int unsigned SUM_HI_W = SUM_W - SUM_LO_W;
  localparam int unsigned P_W      = GAIN_W + ERR_W;     // proportional product
  localparam int unsigned D_W      = GAIN_W + DIFF_W;    // derivative product
  localparam int unsigned IH_W     = GAIN_W + SUM_HI_W;  // integral, high partial
  localparam int unsigned IL_W     = GAIN_W + SUM_LO_W + 1; // integral, low partial
  localparam int unsigned INT_W    = IH_W + SUM_LO_W;    // full integral product
  localparam int unsigned ISAT_W   = 62;                 // integral after +-2^60 cap
  localparam int unsigned PD_W     = D_W + 1;            // P plus D
  localparam int unsigned ACC_W    = ISAT_W + 1;         // full PID accumulator
  localparam int unsigned CORR_W   = ERR_W;              // clamped corrections
  localparam int unsigned OUTS_W   = CORR_W + 1;         // correction sum before clamp

  // Output scaling of the two loops
  localparam int unsigned DIST_SHIFT = 10;
  localparam int unsigned HEAD_SHIFT = 9;

  // Tolerances and limits
  localparam int unsigned DIST_TOLERANCE  = 40;
  localparam int unsigned HEAD_TOLERANCE  = 25;
  localparam int unsigned DRIVE_LIMIT     = 32767;
  localparam int unsigned HEAD_CORR_LIMIT = 18022;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_DIST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_HEAD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_PROP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_INTEG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_DERIV = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_PROP  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_INTEG = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_DERIV = 3'd7;

  // Input beat
  typedef struct packed {
    logic signed [CNT_W-1:0] left_count;
    logic signed [CNT_W-1:0] right_count_raw;
    logic                    restart;
  } in_beat_t;

  // Output beat
  typedef struct packed {
    logic signed [DRV_W-1:0] left_drive;
    logic signed [DRV_W-1:0] right_drive;
    logic                    goal_reached;
  } out_beat_t;

  // Configuration registers
  typedef struct packed {
    logic signed [GOAL_W-1:0] goal_distance;
    logic signed [GOAL_W-1:0] goal_heading;
    logic signed [GAIN_W-1:0] dist_prop_gain;
    logic signed [GAIN_W-1:0] dist_integral_gain;
    logic signed [GAIN_W-1:0] dist_deriv_gain;
    logic signed [GAIN_W-1:0] head_prop_gain;
    logic signed [GAIN_W-1:0] head_integral_gain;
    logic signed [GAIN_W-1:0] head_deriv_gain;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    goal_distance:      16'sd0,
    goal_heading:       16'sd0,
    dist_prop_gain:     32'sd83886,
    dist_integral_gain: 32'sd0,
    dist_deriv_gain:    32'sd10066329,
    head_prop_gain:     32'sd11744,
    head_integral_gain: 32'sd0,
    head_deriv_gain:    32'sd2516582
  };

  // Error stage result
  typedef struct packed {
    logic signed [ERR_W-1:0]  ed;
    logic signed [DIFF_W-1:0] dd;
    logic signed [SUM_W-1:0]  dsum;
    logic signed [ERR_W-1:0]  eh;
    logic signed [DIFF_W-1:0] dh;
    logic signed [SUM_W-1:0]  hsum;
    logic                     done;
  } err_t;

  // Product stage result
  typedef struct packed {
    logic signed [P_W-1:0]  dp;
    logic signed [D_W-1:0]  dd;
    logic signed [IH_W-1:0] dih;
    logic signed [IL_W-1:0] dil;
    logic signed [P_W-1:0]  hp;
    logic signed [D_W-1:0]  hd;
    logic signed [IH_W-1:0] hih;
    logic signed [IL_W-1:0] hil;
    logic                   done;
  } prod_t;

  // Integral-capped partial sums
  typedef struct packed {
    logic signed [ISAT_W-1:0] di;
    logic signed [PD_W-1:0]   dpd;
    logic signed [ISAT_W-1:0] hi;
    logic signed [PD_W-1:0]   hpd;
    logic                     done;
  } mix_t;

  // Clamped corrections
  typedef struct packed {
    logic signed [CORR_W-1:0] dc;
    logic signed [CORR_W-1:0] hc;
    logic                     done;
  } corr_t;

endpackage

// ===== hw/rtl/dwpd_err.sv =====
// Error stage: count conditioning, errors, saturating sums and loop state.
`timescale 1ns / 1ps

module dwpd_err import dwpd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  in_beat_t beat_i,
  input  cfg_t     cfg_i,
  output err_t     err_o
);

  localparam logic signed [CNT_W-1:0] RAW_MIN = {1'b1, {(CNT_W-1){1'b0}}};
  localparam logic signed [CNT_W-1:0] RAW_MAX = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic signed [ERR_W-1:0] DIST_BAND = ERR_W'(2 * DIST_TOLERANCE);
  localparam logic signed [ERR_W-1:0] HEAD_BAND = ERR_W'(HEAD_TOLERANCE);

  // loop state
  logic signed [ERR_W-1:0] prev_ed_q, prev_eh_q;
  logic signed [SUM_W-1:0] dsum_q, hsum_q;
  logic                    done_q;

  logic signed [CNT_W-1:0]    right;
  logic signed [TRAVEL_W-1:0] travel, spread;
  logic signed [ERR_W-1:0]    ed, eh, pd, ph;
  logic signed [SUM_W-1:0]    dbase, hbase;
  logic                       done_base;
  err_t                       err_d, err_q;

  // add one error to a sum, saturating at the sum's range
  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] base,
                                                      input logic signed [ERR_W-1:0] e);
    logic [SUM_W:0] s;
    s = {base[SUM_W-1], base} + {{(SUM_W+1-ERR_W){e[ERR_W-1]}}, e};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return s[SUM_W-1:0];
  endfunction

  // errors and next state
  always_comb begin
    right  = (beat_i.right_count_raw == RAW_MIN) ? RAW_MAX : -beat_i.right_count_raw;
    travel = {beat_i.left_count[CNT_W-1], beat_i.left_count} + {right[CNT_W-1], right};
    spread = {beat_i.left_count[CNT_W-1], beat_i.left_count} - {right[CNT_W-1], right};
    ed     = {cfg_i.goal_distance[GOAL_W-1], cfg_i.goal_distance, 1'b0}
             - {travel[TRAVEL_W-1], travel};
    eh     = {{2{cfg_i.goal_heading[GOAL_W-1]}}, cfg_i.goal_heading}
             - {spread[TRAVEL_W-1], spread};

    // restart clears the state before this tick
    pd        = beat_i.restart ? '0 : prev_ed_q;
    ph        = beat_i.restart ? '0 : prev_eh_q;
    dbase     = beat_i.restart ? '0 : dsum_q;
    hbase     = beat_i.restart ? '0 : hsum_q;
    done_base = beat_i.restart ? 1'b0 : done_q;

    err_d.ed   = ed;
    err_d.eh   = eh;
    err_d.dd   = {ed[ERR_W-1], ed} - {pd[ERR_W-1], pd};
    err_d.dh   = {eh[ERR_W-1], eh} - {ph[ERR_W-1], ph};
    err_d.dsum = sat_add(dbase, ed);
    err_d.hsum = sat_add(hbase, eh);
    err_d.done = done_base
                 || ((cfg_i.goal_distance != '0) && (ed > -DIST_BAND) && (ed < DIST_BAND))
                 || ((cfg_i.goal_heading != '0) && (eh > -HEAD_BAND) && (eh < HEAD_BAND));
  end

  // state update, once per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ed_q <= '0;
      prev_eh_q <= '0;
      dsum_q    <= '0;
      hsum_q    <= '0;
      done_q    <= 1'b0;
    end else if (load_i) begin
      prev_ed_q <= ed;
      prev_eh_q <= eh;
      dsum_q    <= err_d.dsum;
      hsum_q    <= err_d.hsum;
      done_q    <= err_d.done;
    end
  end

  // stage register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      err_q <= err_d;
    end
  end

  assign err_o = err_q;

endmodule

// ===== hw/rtl/dwpd_mul.sv =====
// Product stage: the six gain multiplications, integral split in two halves.
`timescale 1ns / 1ps

module dwpd_mul import dwpd_pkg::*; (
  input  logic  clk_i,
  input  logic  load_i,
  input  err_t  err_i,
  input  cfg_t  cfg_i,
  output prod_t prod_o
);

  prod_t prod_d, prod_q;

  // gain products; each sum is split so no multiplier exceeds 32 x 21
  always_comb begin
    prod_d.dp   = P_W'(cfg_i.dist_prop_gain) * P_W'(err_i.ed);
    prod_d.dd   = D_W'(cfg_i.dist_deriv_gain) * D_W'(err_i.dd);
    prod_d.dih  = IH_W'(cfg_i.dist_integral_gain)
                  * IH_W'($signed(err_i.dsum[SUM_W-1:SUM_LO_W]));
    prod_d.dil  = IL_W'(cfg_i.dist_integral_gain)
                  * IL_W'($signed({1'b0, err_i.dsum[SUM_LO_W-1:0]}));
    prod_d.hp   = P_W'(cfg_i.head_prop_gain) * P_W'(err_i.eh);
    prod_d.hd   = D_W'(cfg_i.head_deriv_gain) * D_W'(err_i.dh);
    prod_d.hih  = IH_W'(cfg_i.head_integral_gain)
                  * IH_W'($signed(err_i.hsum[SUM_W-1:SUM_LO_W]));
    prod_d.hil  = IL_W'(cfg_i.head_integral_gain)
                  * IL_W'($signed({1'b0, err_i.hsum[SUM_LO_W-1:0]}));
    prod_d.done = err_i.done;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== hw/rtl/dwpd_mix.sv =====
// Combine stages: integral cap, PID sums, scaling and correction clamps.
`timescale 1ns / 1ps

module dwpd_mix import dwpd_pkg::*; (
  input  logic  clk_i,
  input  logic  load_sum_i,
  input  logic  load_corr_i,
  input  prod_t prod_i,
  input  cfg_t  cfg_i,
  output corr_t corr_o
);

  localparam logic signed [INT_W-1:0] ICAP   = INT_W'(1) <<< (ISAT_W - 2);
  localparam logic signed [ACC_W-1:0] DC_LIM = ACC_W'(2 ** (CORR_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] HC_LIM = ACC_W'(HEAD_CORR_LIMIT);

  logic signed [INT_W-1:0] di_full, hi_full;
  logic signed [ACC_W-1:0] dacc, hacc, dsh, hsh;
  mix_t                    mix_d, mix_q;
  corr_t                   corr_d, corr_q;

  // cap an integral product to +-2^60
  function automatic logic signed [ISAT_W-1:0] cap_term(input logic signed [INT_W-1:0] x);
    if (x > ICAP) begin
      return ISAT_W'(ICAP);
    end
    if (x < -ICAP) begin
      return ISAT_W'(-ICAP);
    end
    return ISAT_W'(x);
  endfunction

  // symmetric clamp into a correction
  function automatic logic signed [CORR_W-1:0] clamp_corr(input logic signed [ACC_W-1:0] x,
                                                          input logic signed [ACC_W-1:0] lim);
    if (x > lim) begin
      return CORR_W'(lim);
    end
    if (x < -lim) begin
      return CORR_W'(-lim);
    end
    return CORR_W'(x);
  endfunction

  // join integral halves and cap; add P and D
  always_comb begin
    di_full    = (INT_W'(prod_i.dih) <<< SUM_LO_W) + INT_W'(prod_i.dil);
    hi_full    = (INT_W'(prod_i.hih) <<< SUM_LO_W) + INT_W'(prod_i.hil);
    mix_d.di   = cap_term(di_full);
    mix_d.hi   = cap_term(hi_full);
    mix_d.dpd  = PD_W'(prod_i.dp) + PD_W'(prod_i.dd);
    mix_d.hpd  = PD_W'(prod_i.hp) + PD_W'(prod_i.hd);
    mix_d.done = prod_i.done;
  end

  always_ff @(posedge clk_i) begin
    if (load_sum_i) begin
      mix_q <= mix_d;
    end
  end

  // full sums, floor scaling to Q3.15, clamps
  always_comb begin
    dacc = ACC_W'(mix_q.di) + ACC_W'(mix_q.dpd);
    hacc = ACC_W'(mix_q.hi) + ACC_W'(mix_q.hpd);
    dsh  = dacc >>> DIST_SHIFT;
    hsh  = hacc >>> HEAD_SHIFT;
    // distance correction is narrowed well past any value the drive clamp lets through
    corr_d.dc   = clamp_corr(dsh, DC_LIM);
    // heading loop is off while its goal is zero
    corr_d.hc   = (cfg_i.goal_heading == '0) ? '0 : clamp_corr(hsh, HC_LIM);
    corr_d.done = mix_q.done;
  end

  always_ff @(posedge clk_i) begin
    if (load_corr_i) begin
      corr_q <= corr_d;
    end
  end

  assign corr_o = corr_q;

endmodule

// ===== hw/rtl/dual_wheel_pid_drive.sv =====
// Top level of the dual-wheel PID drive: config registers, pipeline control, output stage.
`timescale 1ns / 1ps

// Differential-drive PID controller. Each input beat is one control tick carrying the two
// encoder counts; each tick gives exactly one output beat with the left and right drive
// (Q1.15, clamped) and the sticky goal flag. The datapath is a six-register pipeline
// (input, error/state, products, integral cap, scaling, output), and one beat can enter
// every cycle while the output is not stalled. The loop state (previous errors, sums,
// done flag) is updated in the error stage as each beat loads into it, which is what
// lets ticks follow back to back. Bubbles close up under output stall; in_stall_o rises
// only once all six stages hold beats. Config registers are written through a simple
// write port and must only change while no tick is in flight.
module dual_wheel_pid_drive import dwpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_beat_o
);

  localparam int unsigned NSTG = 6;
  localparam logic signed [OUTS_W-1:0] DRV_LIM = OUTS_W'(DRIVE_LIMIT);

  cfg_t            cfg_q;
  logic [NSTG-1:0] vld_q, vld_d, load, free;
  in_beat_t        in_q;
  err_t            err;
  prod_t           prod;
  corr_t           corr;
  out_beat_t       out_d, out_q;
  logic signed [OUTS_W-1:0] lsum, rsum;

  function automatic logic signed [DRV_W-1:0] clamp_drv(input logic signed [OUTS_W-1:0] x);
    if (x > DRV_LIM) begin
      return DRV_W'(DRV_LIM);
    end
    if (x < -DRV_LIM) begin
      return DRV_W'(-DRV_LIM);
    end
    return DRV_W'(x);
  endfunction

  // config write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GOAL_DIST:  cfg_q.goal_distance      <= cfg_data_i[GOAL_W-1:0];
        REG_GOAL_HEAD:  cfg_q.goal_heading       <= cfg_data_i[GOAL_W-1:0];
        REG_DIST_PROP:  cfg_q.dist_prop_gain     <= cfg_data_i[GAIN_W-1:0];
        REG_DIST_INTEG: cfg_q.dist_integral_gain <= cfg_data_i[GAIN_W-1:0];
        REG_DIST_DERIV: cfg_q.dist_deriv_gain    <= cfg_data_i[GAIN_W-1:0];
        REG_HEAD_PROP:  cfg_q.head_prop_gain     <= cfg_data_i[GAIN_W-1:0];
        REG_HEAD_INTEG: cfg_q.head_integral_gain <= cfg_data_i[GAIN_W-1:0];
        REG_HEAD_DERIV: cfg_q.head_deriv_gain    <= cfg_data_i[GAIN_W-1:0];
      endcase
    end
  end

  // stage advance: a stage loads when it is empty or its beat moves on
  always_comb begin
    free[NSTG-1] = !vld_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      load[k+1] = vld_q[k] && free[k+1];
      free[k]   = !vld_q[k] || load[k+1];
    end
    load[0] = in_valid_i && free[0];

    for (int k = 0; k < NSTG - 1; k++) begin
      vld_d[k] = load[k] || (vld_q[k] && !load[k+1]);
    end
    vld_d[NSTG-1] = load[NSTG-1] || (vld_q[NSTG-1] && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      in_q <= in_beat_i;
    end
  end

  dwpd_err u_err (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load[1]),
    .beat_i (in_q),
    .cfg_i  (cfg_q),
    .err_o  (err)
  );

  dwpd_mul u_mul (
    .clk_i  (clk_i),
    .load_i (load[2]),
    .err_i  (err),
    .cfg_i  (cfg_q),
    .prod_o (prod)
  );

  dwpd_mix u_mix (
    .clk_i       (clk_i),
    .load_sum_i  (load[3]),
    .load_corr_i (load[4]),
    .prod_i      (prod),
    .cfg_i       (cfg_q),
    .corr_o      (corr)
  );

  // drive mix and clamp
  always_comb begin
    lsum               = {corr.dc[CORR_W-1], corr.dc} - {corr.hc[CORR_W-1], corr.hc};
    rsum               = {corr.dc[CORR_W-1], corr.dc} + {corr.hc[CORR_W-1], corr.hc};
    out_d.left_drive   = clamp_drv(lsum);
    out_d.right_drive  = clamp_drv(rsum);
    out_d.goal_reached = corr.done;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load[NSTG-1]) begin
      out_q <= out_d;
    end
  end

  assign in_stall_o  = !free[0];
  assign out_valid_o = vld_q[NSTG-1];
  assign out_beat_o  = out_q;

endmodule

// ===== hw/rtl/dwpd_chk.sv =====
// Port-level checker for the dual-wheel PID drive, bound to the top level.
`timescale 1ns / 1ps

module dwpd_chk import dwpd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_beat_o
);

  localparam int unsigned OCC_MAX = 6;

  logic       in_acc, out_acc;
  logic [3:0] occ_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // beats inside the block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_q + {3'b000, in_acc} - {3'b000, out_acc};
    end
  end

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat withdrawn under stall");

  // and does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_beat_o))
    else $error("output beat changed under stall");

  // with the output side free the input side never stalls
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output side is free");

  // never more beats in flight than pipeline stages
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= 4'(OCC_MAX))
    else $error("more beats held than pipeline stages");

  // no result without an item behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occ_q != '0)
    else $error("result offered with no beat taken");

endmodule

bind dual_wheel_pid_drive dwpd_chk u_chk (.*);
